// ===== hw/rtl/ccsr_pkg.sv =====
package ccsr_pkg;

	localparam int COORD_INT_BITS  = 12;
	localparam int FRAC_BITS       = 4;
	localparam int RADIUS_INT_BITS = 5;

	localparam int COORD_W   = COORD_INT_BITS + FRAC_BITS;
	localparam int RAD_W     = RADIUS_INT_BITS + FRAC_BITS;
	localparam int DIM_W     = COORD_INT_BITS + 1;
	localparam int IDX_W     = 2 * COORD_INT_BITS;
	localparam int DIM_LIMIT = 1 << COORD_INT_BITS;
	localparam int UNIT_M1   = (1 << FRAC_BITS) - 1;

	// signed work width for centre/radius arithmetic
	localparam int XW = ((COORD_W > RAD_W) ? COORD_W : RAD_W) + 2;

	localparam int MUL_A_W = (RAD_W > COORD_INT_BITS) ? RAD_W : COORD_INT_BITS;
	localparam int MUL_B_W = (RAD_W > DIM_W) ? RAD_W : DIM_W;

	localparam int SPAN_MAX   = 64;
	localparam int SPAN_CNT_W = $clog2(SPAN_MAX);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] centre_x;
		logic [COORD_W-1:0] centre_y;
		logic [RAD_W-1:0]   radius;
	} circle_t;

	typedef struct packed {
		logic [COORD_INT_BITS-1:0] column;
		logic [COORD_INT_BITS-1:0] top_row;
		logic [COORD_INT_BITS-1:0] bottom_row;
		logic [IDX_W-1:0]          start_index;
		logic                      empty_res;
		logic                      last;
	} span_t;

endpackage

// ===== hw/rtl/ccsr_isqrt.sv =====
module ccsr_isqrt #(
	parameter int ROOT_W = ccsr_pkg::RAD_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   value,
	output logic                  done,
	output logic [ROOT_W-1:0]     root
);
	localparam int CNT_W = $clog2(ROOT_W + 1);
	localparam int RW    = ROOT_W + 3;

	logic [2*ROOT_W-1:0] rad_q;
	logic [ROOT_W:0]     rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [RW-1:0]     rem_try;
	logic [RW-1:0]     trial;
	logic              fits;
	logic [RW-1:0]     rem_sub;

	assign rem_try = {rem_q, rad_q[2*ROOT_W-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign fits    = (rem_try >= trial);
	assign rem_sub = rem_try - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(ROOT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= rem_sub[ROOT_W:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_try[ROOT_W:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("isqrt restarted while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && cnt_q == CNT_W'(ROOT_W))
		else $error("isqrt did not load");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("isqrt done without work");

endmodule

// ===== hw/rtl/ccsr_out_reg.sv =====
module ccsr_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ccsr_pkg::span_t push_data,
	output logic            can_push,
	output logic            span_valid,
	input  logic            span_stall,
	output ccsr_pkg::span_t span
);
	import ccsr_pkg::*;

	logic  vld_q;
	span_t data_q;

	assign can_push = !vld_q || !span_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (push && can_push) begin
			vld_q <= 1'b1;
		end else if (!span_stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && can_push) begin
			data_q <= push_data;
		end
	end

	assign span_valid = vld_q;
	assign span       = data_q;

endmodule

// ===== hw/rtl/circle_column_span_rasterizer.sv =====
// channel  | direction | handshake                 | payload
// circle   | in        | circle_valid/circle_stall | circle_t: centre_x, centre_y, radius
// span     | out       | span_valid/span_stall     | span_t: one column per item, or an empty item on a miss
// cfg      | in        | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// A circle runs range setup (S_LO, S_HI, S_CHK), then S_DIF through S_EMIT for each column,
// with the column time set by the one-bit-per-cycle square root unit.
// A circle that misses the image goes to S_MISS and pushes one empty, last span.
// circle_stall is high after acceptance until the last span enters the output register.
// After reset both image dimensions are 4096; cfg_ready is always high.
// span_stall holds the output register; the sequencer waits only when it is full.
module circle_column_span_rasterizer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                circle_valid,
	output logic                                circle_stall,
	input  ccsr_pkg::circle_t                   circle,
	output logic                                span_valid,
	input  logic                                span_stall,
	output ccsr_pkg::span_t                     span,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ccsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ccsr_pkg::DIM_W-1:0]          cfg_data
);
	import ccsr_pkg::*;

	localparam int CIB = COORD_INT_BITS;
	localparam int PW  = MUL_A_W + MUL_B_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LO   = 4'd1;
	localparam logic [3:0] S_HI   = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_MISS = 4'd4;
	localparam logic [3:0] S_DIF  = 4'd5;
	localparam logic [3:0] S_MD   = 4'd6;
	localparam logic [3:0] S_SUB  = 4'd7;
	localparam logic [3:0] S_ROOT = 4'd8;
	localparam logic [3:0] S_TOP  = 4'd9;
	localparam logic [3:0] S_BOT  = 4'd10;
	localparam logic [3:0] S_CMP  = 4'd11;
	localparam logic [3:0] S_EMIT = 4'd12;

	logic [3:0]       state_q;
	logic [DIM_W-1:0] cfg_w_q;
	logic [DIM_W-1:0] cfg_h_q;

	circle_t               lat_q;
	logic [DIM_W-1:0]      w_q;
	logic [DIM_W-1:0]      h_q;
	logic [DIM_W-1:0]      lo_q;
	logic [DIM_W-1:0]      hi_q;
	logic [2*RAD_W-1:0]    rr_q;
	logic [CIB-1:0]        col_q;
	logic [SPAN_CNT_W-1:0] n_q;
	logic [RAD_W-1:0]      d_q;
	logic [DIM_W-1:0]      top_q;
	logic [DIM_W-1:0]      bot_q;
	logic                  emp_q;
	logic [PW-1:0]         prod_q;

	logic                accept;
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [PW-1:0]       mul_p;
	logic signed [XW-1:0] lo_t, lo_sh, d_t, top_t, top_sh;
	logic [XW-1:0]       hi_s, bot_s, d_abs;
	logic [DIM_W-1:0]    lo_c, hi_raw, hi_c, bot_raw, bot_c, top_c;
	logic                miss;
	logic                last_c;
	logic                sq_start;
	logic                sq_done;
	logic [RAD_W-1:0]    q;
	logic                push;
	logic                can_push;
	span_t               push_data;

	assign cfg_ready    = 1'b1;
	assign circle_stall = (state_q != S_IDLE);
	assign accept       = circle_valid && !circle_stall;

	// range of columns
	assign lo_t  = XW'(lat_q.centre_x) - XW'(lat_q.radius) + XW'(UNIT_M1);
	assign lo_sh = lo_t >>> FRAC_BITS;
	assign lo_c  = lo_sh[XW-1] ? '0 : lo_sh[DIM_W-1:0];
	assign hi_s  = (XW'(lat_q.centre_x) + XW'(lat_q.radius)) >> FRAC_BITS;
	assign hi_raw = hi_s[DIM_W-1:0];
	assign hi_c  = (hi_raw > w_q - DIM_W'(1)) ? w_q - DIM_W'(1) : hi_raw;
	assign miss  = (w_q == '0) || (lo_q > hi_q);

	// offset of the column from the centre
	assign d_t   = XW'(XW'(col_q) << FRAC_BITS) - XW'(lat_q.centre_x);
	assign d_abs = d_t[XW-1] ? XW'(-d_t) : XW'(d_t);

	// rows
	assign top_t  = XW'(lat_q.centre_y) - XW'(q) + XW'(UNIT_M1);
	assign top_sh = top_t >>> FRAC_BITS;
	assign top_c  = top_sh[XW-1] ? '0 : top_sh[DIM_W-1:0];
	assign bot_s  = (XW'(lat_q.centre_y) + XW'(q)) >> FRAC_BITS;
	assign bot_raw = bot_s[DIM_W-1:0];
	assign bot_c  = (h_q != '0 && bot_raw > h_q - DIM_W'(1)) ? h_q - DIM_W'(1) : bot_raw;

	assign last_c = (DIM_W'(col_q) == hi_q) || (n_q == SPAN_CNT_W'(SPAN_MAX - 1));

	// shared multiplier: r*r, d*d, column*height
	always_comb begin
		unique case (state_q)
			S_LO: begin
				mul_a = MUL_A_W'(lat_q.radius);
				mul_b = MUL_B_W'(lat_q.radius);
			end
			S_MD: begin
				mul_a = MUL_A_W'(d_q);
				mul_b = MUL_B_W'(d_q);
			end
			default: begin
				mul_a = MUL_A_W'(col_q);
				mul_b = MUL_B_W'(h_q);
			end
		endcase
	end
	assign mul_p = PW'(mul_a) * PW'(mul_b);

	assign sq_start = (state_q == S_SUB);

	ccsr_isqrt #(
		.ROOT_W(RAD_W)
	) u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.value (rr_q - prod_q[2*RAD_W-1:0]),
		.done  (sq_done),
		.root  (q)
	);

	always_comb begin
		push_data = '0;
		push      = 1'b0;
		if (state_q == S_MISS) begin
			push                = 1'b1;
			push_data.empty_res = 1'b1;
			push_data.last      = 1'b1;
		end else if (state_q == S_EMIT) begin
			push             = 1'b1;
			push_data.column = col_q;
			push_data.last   = last_c;
			if (emp_q) begin
				push_data.empty_res = 1'b1;
			end else begin
				push_data.top_row     = top_q[CIB-1:0];
				push_data.bottom_row  = bot_q[CIB-1:0];
				push_data.start_index = IDX_W'(prod_q) + IDX_W'(top_q);
			end
		end
	end

	ccsr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.can_push  (can_push),
		.span_valid(span_valid),
		.span_stall(span_stall),
		.span      (span)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cfg_w_q <= DIM_W'(DIM_LIMIT);
			cfg_h_q <= DIM_W'(DIM_LIMIT);
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  cfg_w_q <= cfg_data;
					REG_IMAGE_HEIGHT: cfg_h_q <= cfg_data;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_LO;
				S_LO:   state_q <= S_HI;
				S_HI:   state_q <= S_CHK;
				S_CHK:  state_q <= miss ? S_MISS : S_DIF;
				S_MISS: if (can_push) state_q <= S_IDLE;
				S_DIF:  state_q <= S_MD;
				S_MD:   state_q <= S_SUB;
				S_SUB:  state_q <= S_ROOT;
				S_ROOT: if (sq_done) state_q <= S_TOP;
				S_TOP:  state_q <= S_BOT;
				S_BOT:  state_q <= S_CMP;
				S_CMP:  state_q <= S_EMIT;
				S_EMIT: if (can_push) state_q <= last_c ? S_IDLE : S_DIF;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					lat_q <= circle;
					w_q   <= (cfg_w_q > DIM_W'(DIM_LIMIT)) ? DIM_W'(DIM_LIMIT) : cfg_w_q;
					h_q   <= (cfg_h_q > DIM_W'(DIM_LIMIT)) ? DIM_W'(DIM_LIMIT) : cfg_h_q;
				end
			end
			S_LO: lo_q <= lo_c;
			S_HI: begin
				hi_q <= hi_c;
				rr_q <= prod_q[2*RAD_W-1:0];
			end
			S_CHK: begin
				col_q <= lo_q[CIB-1:0];
				n_q   <= '0;
			end
			S_DIF: d_q <= d_abs[RAD_W-1:0];
			S_TOP: top_q <= top_c;
			S_BOT: bot_q <= bot_c;
			S_CMP: emp_q <= (h_q == '0) || (top_q > bot_q);
			S_EMIT: begin
				if (can_push && !last_c) begin
					col_q <= col_q + CIB'(1);
					n_q   <= n_q + SPAN_CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_LO)
		else $error("circle accepted but range setup not started");
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		push && can_push && !push_data.empty_res |->
			push_data.top_row <= push_data.bottom_row)
		else $error("non-empty span with top below bottom");
	a_span_hold: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && span_stall |=> span_valid && $stable(span))
		else $error("stalled span changed");

endmodule
